@@ hw/rtl/clook_seek_distance_macros.svh @@
// ----------------------------------------------------------------------------
// clook_seek_distance_macros.svh
// Assertion shorthands for the C-LOOK seek distance block. The assertions use
// the clk and rst_n of the scope in which they are written.
// ----------------------------------------------------------------------------
`ifndef CLOOK_SEEK_DISTANCE_MACROS_SVH
`define CLOOK_SEEK_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CLSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CLSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/clsd_pkg.sv @@
// ----------------------------------------------------------------------------
// clsd_pkg
// Shared types and constants of the C-LOOK seek distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package clsd_pkg;

    // Fixed field widths
    localparam int CLSD_FIELD_W     = 16;
    localparam int CLSD_DIST_W      = 23;
    localparam int CLSD_CFG_IDX_W   = 2;
    localparam int CLSD_CFG_DATA_W  = 16;

    // Parameter defaults
    localparam int CLSD_MAX_REQUESTS = 64;
    localparam int CLSD_TRACK_BITS   = 16;

    localparam logic [CLSD_DIST_W-1:0] CLSD_DIST_MAX = '1;

    // Register indexes
    localparam logic [CLSD_CFG_IDX_W-1:0] REG_START_HEAD = 2'd0;
    localparam logic [CLSD_CFG_IDX_W-1:0] REG_MOVE_UP    = 2'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_CLASS,
        ST_MIN,
        ST_MAX,
        ST_DIST,
        ST_DONE
    } clsd_state_t;

    // Head moves of the distance pass: first sweep, jump, second sweep
    typedef enum logic [1:0] {
        STEP_SWEEP1,
        STEP_JUMP,
        STEP_SWEEP2
    } clsd_step_t;

    // Sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic read_en;
        logic class_en;
        logic min_en;
        logic max_en;
        logic dist_en;
        logic out_valid;
    } clsd_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic last_accept;
        logic last_entry;
        logic last_step;
        logic out_taken;
    } clsd_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/clsd_channels.sv @@
// ----------------------------------------------------------------------------
// clsd_channels
// Valid/ready channel interfaces: request words, result words and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsd_req_if import clsd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CLSD_FIELD_W-1:0] request_track;
    logic                    is_last;

    modport source (output valid, output request_track, output is_last, input ready);
    modport sink   (input valid, input request_track, input is_last, output ready);
endinterface

interface clsd_res_if import clsd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CLSD_DIST_W-1:0] total_distance;

    modport source (output valid, output total_distance, input ready);
    modport sink   (input valid, input total_distance, output ready);
endinterface

interface clsd_cfg_if import clsd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CLSD_CFG_IDX_W-1:0]  index;
    logic [CLSD_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/clsd_ram.sv @@
// ----------------------------------------------------------------------------
// clsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/clsd_alu.sv @@
// ----------------------------------------------------------------------------
// clsd_alu
// Shared subtract unit: less-than flag and absolute difference of two tracks.
// ----------------------------------------------------------------------------
`default_nettype none

module clsd_alu #(
    parameter int W = 16
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output      logic         lt,
    output      logic [W-1:0] absdiff
);

    logic [W:0] diff;

    // Borrow out of a - b gives a < b
    always_comb
    begin
        diff    = {1'b0, a} - {1'b0, b};
        lt      = diff[W];
        absdiff = lt ? (~diff[W-1:0] + W'(1)) : diff[W-1:0];
    end

endmodule

`default_nettype wire

@@ hw/rtl/clsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// clsd_ctrl
// Sequencer: batch load, per-entry classify/min/max sweep, distance pass and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module clsd_ctrl import clsd_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire clsd_stat_t stat,
    output      clsd_ctrl_t ctrl
);

    clsd_state_t state_reg;
    clsd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (stat.last_accept) state_next = ST_READ;
            ST_READ:  state_next = ST_CLASS;
            ST_CLASS: state_next = ST_MIN;
            ST_MIN:   state_next = ST_MAX;
            ST_MAX:   state_next = stat.last_entry ? ST_DIST : ST_READ;
            ST_DIST:  if (stat.last_step) state_next = ST_DONE;
            ST_DONE:  if (stat.out_taken) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_LOAD:  ctrl.in_ready  = 1'b1;
            ST_READ:  ctrl.read_en   = 1'b1;
            ST_CLASS: ctrl.class_en  = 1'b1;
            ST_MIN:   ctrl.min_en    = 1'b1;
            ST_MAX:   ctrl.max_en    = 1'b1;
            ST_DIST:  ctrl.dist_en   = 1'b1;
            ST_DONE:  ctrl.out_valid = 1'b1;
            default:  ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/clook_seek_distance.sv @@
// ----------------------------------------------------------------------------
// clook_seek_distance
// C-LOOK total head travel over a batch of track requests.
// ----------------------------------------------------------------------------
// Usage:
//   req: one request word per accepted cycle (request_track, is_last). Words
//   load at one per cycle into the request RAM; words past MAX_REQUESTS are
//   dropped. The word with is_last set closes the batch.
//   cfg: register writes (start_head, move_up), always ready; write only while
//   the block is idle between batches.
//   res: one word, total_distance (saturated at 23 bits), per batch.
// Timing: after the closing word is accepted, req.ready drops. A sweep reads
//   each stored request once and uses the shared subtract unit three times on
//   it (one RAM read, then three compares), then three head moves go through
//   the same unit.
// Stall: the result holds on res until taken; req.ready stays low until then.
// Reset: clears the batch count, the sequencer, and sets start_head to 0 and
//   move_up to 1. The request RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module clook_seek_distance import clsd_pkg::*; #(
    parameter int MAX_REQUESTS = CLSD_MAX_REQUESTS,
    parameter int TRACK_BITS   = CLSD_TRACK_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    clsd_req_if.sink   req,
    clsd_res_if.source res,
    clsd_cfg_if.sink   cfg
);

    localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int COPY_W = (TRACK_BITS < CLSD_FIELD_W) ? TRACK_BITS : CLSD_FIELD_W;
    localparam int SUM_W  = ((TRACK_BITS > CLSD_DIST_W) ? TRACK_BITS : CLSD_DIST_W) + 1;

    clsd_ctrl_t ctrl;
    clsd_stat_t stat;

    // Configuration registers
    logic [CLSD_FIELD_W-1:0] start_head_reg;
    logic                    move_up_reg;

    // Batch and sweep control
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    clsd_step_t        step_reg, step_next;
    logic              lo_any_reg, lo_any_next;
    logic              hi_any_reg, hi_any_next;
    logic [CLSD_DIST_W-1:0] acc_reg, acc_next;

    // Datapath payload
    logic [TRACK_BITS-1:0] entry_reg;
    logic                  high_reg, high_next;
    logic [TRACK_BITS-1:0] lo_min_reg, lo_min_next;
    logic [TRACK_BITS-1:0] lo_max_reg, lo_max_next;
    logic [TRACK_BITS-1:0] hi_min_reg, hi_min_next;
    logic [TRACK_BITS-1:0] hi_max_reg, hi_max_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;

    logic                  in_accept;
    logic                  store_we;
    logic [TRACK_BITS-1:0] track_in;
    logic [TRACK_BITS-1:0] start_trk;
    logic [TRACK_BITS-1:0] ram_rdata;
    logic [TRACK_BITS-1:0] alu_a, alu_b, alu_abs;
    logic                  alu_lt;
    logic [TRACK_BITS-1:0] set_min, set_max;
    logic                  set_any;
    logic                  move_en;
    logic [TRACK_BITS-1:0] move_tgt;
    logic [SUM_W-1:0]      sum;

    assign in_accept = req.valid && req.ready;
    assign store_we  = in_accept && (count_reg < CNT_W'(MAX_REQUESTS));
    assign track_in  = TRACK_BITS'(req.request_track[COPY_W-1:0]);
    assign start_trk = TRACK_BITS'(start_head_reg[COPY_W-1:0]);

    // Handshakes
    assign req.ready          = ctrl.in_ready;
    assign res.valid          = ctrl.out_valid;
    assign res.total_distance = acc_reg;
    assign cfg.ready          = 1'b1;

    // Status to the sequencer
    always_comb
    begin
        stat.last_accept = in_accept && req.is_last;
        stat.last_entry  = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
        stat.last_step   = (step_reg == STEP_SWEEP2);
        stat.out_taken   = res.valid && res.ready;
    end

    clsd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    clsd_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (track_in),
        .re    (ctrl.read_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Running bounds of the set the current entry belongs to
    assign set_min = high_reg ? hi_min_reg : lo_min_reg;
    assign set_max = high_reg ? hi_max_reg : lo_max_reg;
    assign set_any = high_reg ? hi_any_reg : lo_any_reg;

    // Head move of the current distance step
    always_comb
    begin
        move_en  = 1'b0;
        move_tgt = head_reg;
        unique case (step_reg)
            STEP_SWEEP1:
            begin
                move_en  = move_up_reg ? hi_any_reg : lo_any_reg;
                move_tgt = move_up_reg ? hi_max_reg : lo_min_reg;
            end
            STEP_JUMP:
            begin
                move_en  = move_up_reg ? lo_any_reg : hi_any_reg;
                move_tgt = move_up_reg ? lo_min_reg : hi_max_reg;
            end
            STEP_SWEEP2:
            begin
                move_en  = move_up_reg ? lo_any_reg : hi_any_reg;
                move_tgt = move_up_reg ? lo_max_reg : hi_min_reg;
            end
            default:
            begin
                move_en  = 1'b0;
                move_tgt = head_reg;
            end
        endcase
    end

    // Operand select for the shared unit
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        priority if (ctrl.class_en)
        begin
            alu_a = start_trk;
            alu_b = ram_rdata;
        end
        else if (ctrl.min_en)
        begin
            alu_a = entry_reg;
            alu_b = set_min;
        end
        else if (ctrl.max_en)
        begin
            alu_a = set_max;
            alu_b = entry_reg;
        end
        else if (ctrl.dist_en)
        begin
            alu_a = move_tgt;
            alu_b = head_reg;
        end
    end

    clsd_alu #(
        .W (TRACK_BITS)
    ) u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .lt      (alu_lt),
        .absdiff (alu_abs)
    );

    assign sum = SUM_W'(acc_reg) + SUM_W'(alu_abs);

    // Next values
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        step_next   = step_reg;
        lo_any_next = lo_any_reg;
        hi_any_next = hi_any_reg;
        acc_next    = acc_reg;
        high_next   = high_reg;
        lo_min_next = lo_min_reg;
        lo_max_next = lo_max_reg;
        hi_min_next = hi_min_reg;
        hi_max_next = hi_max_reg;
        head_next   = head_reg;

        // Load; the closing word starts an empty classification
        if (store_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (stat.last_accept)
        begin
            idx_next    = '0;
            lo_any_next = 1'b0;
            hi_any_next = 1'b0;
        end

        // Entry above the start head goes to the high set
        if (ctrl.class_en)
        begin
            high_next = alu_lt;
        end

        if (ctrl.min_en && (!set_any || alu_lt))
        begin
            if (high_reg)
                hi_min_next = entry_reg;
            else
                lo_min_next = entry_reg;
        end

        if (ctrl.max_en)
        begin
            if (!set_any || alu_lt)
            begin
                if (high_reg)
                    hi_max_next = entry_reg;
                else
                    lo_max_next = entry_reg;
            end
            if (high_reg)
                hi_any_next = 1'b1;
            else
                lo_any_next = 1'b1;
            idx_next = idx_reg + ADDR_W'(1);
            // Sweep done: distance pass starts at the configured head
            if (stat.last_entry)
            begin
                head_next = start_trk;
                acc_next  = '0;
                step_next = STEP_SWEEP1;
            end
        end

        // Saturating accumulation of head travel
        if (ctrl.dist_en)
        begin
            if (move_en)
            begin
                acc_next  = (sum > SUM_W'(CLSD_DIST_MAX)) ? CLSD_DIST_MAX
                                                          : sum[CLSD_DIST_W-1:0];
                head_next = move_tgt;
            end
            unique case (step_reg)
                STEP_SWEEP1: step_next = STEP_JUMP;
                STEP_JUMP:   step_next = STEP_SWEEP2;
                STEP_SWEEP2: step_next = STEP_SWEEP1;
                default:     step_next = STEP_SWEEP1;
            endcase
        end

        // Batch closed once the result is taken
        if (stat.out_taken)
        begin
            count_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            step_reg       <= STEP_SWEEP1;
            lo_any_reg     <= 1'b0;
            hi_any_reg     <= 1'b0;
            acc_reg        <= '0;
            start_head_reg <= '0;
            move_up_reg    <= 1'b1;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            step_reg   <= step_next;
            lo_any_reg <= lo_any_next;
            hi_any_reg <= hi_any_next;
            acc_reg    <= acc_next;
            // Register writes; unknown indexes are ignored
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_START_HEAD)
                    start_head_reg <= cfg.data;
                if (cfg.index == REG_MOVE_UP)
                    move_up_reg <= cfg.data[0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.class_en)
        begin
            entry_reg <= ram_rdata;
        end
        high_reg   <= high_next;
        lo_min_reg <= lo_min_next;
        lo_max_reg <= lo_max_next;
        hi_min_reg <= hi_min_next;
        hi_max_reg <= hi_max_next;
        head_reg   <= head_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/clsd_checker.sv @@
// ----------------------------------------------------------------------------
// clsd_checker
// Port-level checks of the C-LOOK seek distance block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clook_seek_distance_macros.svh"

module clsd_checker import clsd_pkg::*; (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic                   req_is_last,
    input wire logic                   res_valid,
    input wire logic                   res_ready,
    input wire logic [CLSD_DIST_W-1:0] res_total_distance
);

    // A pending result blocks new request words
    `CLSD_ASSERT_SAME(a_busy_while_result, res_valid, !req_ready, "request taken while result pending")

    // Closing word is followed by the compute phase
    `CLSD_ASSERT_NEXT(a_close_stops_load, req_valid && req_ready && req_is_last, !req_ready && !res_valid, "load continued after closing word")

    // Stalled result stays up
    `CLSD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // Stalled result keeps its value
    `CLSD_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_total_distance), "result changed while stalled")

endmodule

bind clook_seek_distance clsd_checker u_clsd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_is_last        (req.is_last),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_total_distance (res.total_distance)
);

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clook_seek_distance. Batches of request words go in
// through the req channel, and the block's C-LOOK travel totals come back on
// res. A behavioral C-LOOK travel calculator follows every accepted word and
// queues the expected total for each closing word. Register settings change
// between batches of batches, and both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clsd_pkg::*;

    localparam int TOTAL_WORDS   = 450;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_COUNT = 10;
    localparam int IDLE_SETTLE   = 8;
    localparam int END_SETTLE    = 20;

    // Index with no register behind it; the block must ignore it
    localparam logic [CLSD_CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef logic [CLSD_FIELD_W-1:0] track_t;
    typedef logic [CLSD_DIST_W-1:0]  dist_t;

    typedef struct packed {
        track_t track;
        logic   last;
    } request_word_t;

    logic clk;
    logic rst_n;

    clsd_req_if req_ch ();
    clsd_res_if res_ch ();
    clsd_cfg_if cfg_ch ();

    clook_seek_distance uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    request_word_t word_queue[$];
    dist_t         travel_queue[$];
    track_t        batch_tracks[$];

    request_word_t next_word;
    track_t        head_setting;
    logic          up_setting;
    int            send_gap;
    int            stall_left;
    int            hold_left;
    logic          hold_done;
    logic          sender_gaps_on;
    logic          receiver_stalls_on;
    int            results_seen;
    int            failures;
    int            cycles;
    int            words_made;
    logic          first_random_batch;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(logic enabled);
        int sel;
        sel = $urandom_range(0, 99);
        if (!enabled || sel < 55)
            return 0;
        else if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Track choice: full range, around the head, the ends, a few repeated values
    function automatic track_t pick_track(track_t head);
        int sel;
        int near;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return track_t'($urandom());
        else if (sel < 75)
        begin
            near = int'(head) + $urandom_range(0, 6) - 3;
            if (near < 0)
                near = 0;
            if (near > 65535)
                near = 65535;
            return track_t'(near);
        end
        else if (sel < 85)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        else
            return track_t'($urandom_range(0, 3)) * track_t'(16'h5555);
    endfunction

    // One head move; the running total saturates at the result width
    function automatic longint unsigned seek_add(longint unsigned total, track_t from,
                                                 track_t to);
        longint unsigned step;
        step = (to >= from) ? longint'(to - from) : longint'(from - to);
        total = total + step;
        if (total > longint'(CLSD_DIST_MAX))
            total = longint'(CLSD_DIST_MAX);
        return total;
    endfunction

    // C-LOOK travel over one stored batch
    function automatic dist_t clook_travel(track_t reqs[$], track_t head, logic up);
        track_t          order[$];
        track_t          pos;
        longint unsigned total;
        order = reqs;
        order.sort();
        pos   = head;
        total = 0;
        if (up)
        begin
            // high set ascending, then jump low and go ascending again
            foreach (order[i])
                if (order[i] > head)
                begin
                    total = seek_add(total, pos, order[i]);
                    pos   = order[i];
                end
            foreach (order[i])
                if (order[i] <= head)
                begin
                    total = seek_add(total, pos, order[i]);
                    pos   = order[i];
                end
        end
        else
        begin
            // low set descending, then jump high and go descending again
            for (int i = order.size() - 1; i >= 0; i--)
                if (order[i] <= head)
                begin
                    total = seek_add(total, pos, order[i]);
                    pos   = order[i];
                end
            for (int i = order.size() - 1; i >= 0; i--)
                if (order[i] > head)
                begin
                    total = seek_add(total, pos, order[i]);
                    pos   = order[i];
                end
        end
        return dist_t'(total);
    endfunction

    task automatic push_word(track_t track, logic last);
        request_word_t w;
        w.track = track;
        w.last  = last;
        word_queue.push_back(w);
        words_made++;
    endtask

    // Random batch of n words, closed by the last one
    task automatic push_batch(int n, track_t head);
        for (int i = 0; i < n; i++)
            push_word(pick_track(head), i == n - 1);
    endtask

    // Write both registers, then an unmapped index, with valid held high throughout
    task automatic program_regs(track_t head, logic up);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_START_HEAD;
        cfg_ch.data  <= head;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_MOVE_UP;
        cfg_ch.data  <= {15'($urandom()), up};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_UNMAPPED;
        cfg_ch.data  <= 16'($urandom());
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every queued word went in and every total came back;
    // sampled mid-cycle so the clocked processes have settled
    task automatic wait_idle();
        while (word_queue.size() != 0 || req_ch.valid || batch_tracks.size() != 0
               || travel_queue.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Stimulus and run control
    initial
    begin
        int     batches;
        int     n;
        int     sel;
        track_t head;
        logic   up;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.request_track = '0;
        req_ch.is_last       = 1'b0;
        res_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_START_HEAD;
        cfg_ch.data          = '0;
        sender_gaps_on       = 1'b1;
        receiver_stalls_on   = 1'b1;
        words_made           = 0;
        first_random_batch   = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: head at 0, moving up
        push_word(16'd0, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'd0, 1'b0);
        push_word(16'd100, 1'b1);
        wait_idle();

        // Head at the top, moving down
        program_regs(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'd0, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'd300, 1'b0);
        push_word(16'd300, 1'b1);
        wait_idle();

        // Requests on and next to the head, both directions
        program_regs(16'd1000, 1'b1);
        push_word(16'd1000, 1'b0);
        push_word(16'd999, 1'b0);
        push_word(16'd1001, 1'b0);
        push_word(16'd5, 1'b1);
        wait_idle();
        program_regs(16'd1000, 1'b0);
        push_word(16'd1000, 1'b0);
        push_word(16'd999, 1'b0);
        push_word(16'd1001, 1'b0);
        push_word(16'd5, 1'b1);
        wait_idle();

        // Random phases: new settings, then a few batches
        while (words_made < TOTAL_WORDS)
        begin
            sel  = $urandom_range(0, 99);
            head = (sel < 15) ? 16'd0 : (sel < 30) ? 16'hFFFF : track_t'($urandom());
            up   = 1'($urandom_range(0, 1));
            sender_gaps_on     <= ($urandom_range(0, 3) != 0);
            receiver_stalls_on <= ($urandom_range(0, 3) != 0);
            program_regs(head, up);
            batches = $urandom_range(1, 5);
            for (int b = 0; b < batches && words_made < TOTAL_WORDS; b++)
            begin
                sel = $urandom_range(0, 99);
                if (first_random_batch)
                    n = 70;
                else if (sel < 60)
                    n = $urandom_range(1, 8);
                else if (sel < 85)
                    n = $urandom_range(9, 32);
                else if (sel < 95)
                    n = $urandom_range(33, 64);
                else
                    n = $urandom_range(65, 80);
                first_random_batch = 1'b0;
                push_batch(n, head);
            end
            wait_idle();
        end

        repeat (END_SETTLE) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Request driver: holds a word until taken, then an optional gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.request_track <= '0;
            req_ch.is_last       <= 1'b0;
            send_gap             <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (word_queue.size() != 0)
            begin
                next_word             = word_queue.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.request_track <= next_word.track;
                req_ch.is_last       <= next_word.last;
                send_gap             <= pick_gap(sender_gaps_on);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Predictor: register copy, batch store, expected totals
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            head_setting = '0;
            up_setting   = 1'b1;
            batch_tracks.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                case (cfg_ch.index)
                    REG_START_HEAD: head_setting = cfg_ch.data;
                    REG_MOVE_UP:    up_setting   = cfg_ch.data[0];
                    default:        ;
                endcase
            if (req_ch.valid && req_ch.ready)
            begin
                // words past the store size are dropped
                if (batch_tracks.size() < CLSD_MAX_REQUESTS)
                    batch_tracks.push_back(req_ch.request_track);
                if (req_ch.is_last)
                begin
                    travel_queue.push_back(clook_travel(batch_tracks, head_setting,
                                                        up_setting));
                    batch_tracks.delete();
                end
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off that starts while a
    // result is already stalled and a word is waiting, so the block stays full
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT_COUNT && res_ch.valid
                 && !res_ch.ready && req_ch.valid)
        begin
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (receiver_stalls_on && $urandom_range(0, 99) < 30)
        begin
            stall_left   <= pick_gap(1'b1);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Result checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
            failures     <= 0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (travel_queue.size() == 0)
            begin
                $error("total_distance: no total expected, actual %0d",
                       res_ch.total_distance);
                failures <= failures + 1;
            end
            else if (travel_queue[0] !== res_ch.total_distance)
            begin
                $error("total_distance: expected %0d, actual %0d",
                       travel_queue.pop_front(), res_ch.total_distance);
                failures <= failures + 1;
            end
            else
                void'(travel_queue.pop_front());
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        if (!rst_n)
            cycles <= 0;
        else if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            cycles <= cycles + 1;
    end

endmodule
